// ----- hw/rtl/cda_pkg.sv -----
// shared types, constants and calendar helpers for the date adder
`default_nettype none

package cda_pkg;

  typedef logic [3:0] month_t;
  typedef logic [4:0] day_t;
  typedef logic [8:0] ymod_t;  // year modulo 400

  typedef struct packed {
    logic finish;
    logic overflow;
  } step_stat_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ADD  = 1'b1;

  localparam month_t MON_JAN = 4'd1;
  localparam month_t MON_FEB = 4'd2;
  localparam month_t MON_APR = 4'd4;
  localparam month_t MON_JUN = 4'd6;
  localparam month_t MON_SEP = 4'd9;
  localparam month_t MON_NOV = 4'd11;
  localparam month_t MON_DEC = 4'd12;

  localparam day_t DAY_FIRST  = 5'd1;
  localparam day_t DAY_LAST   = 5'd31;
  localparam day_t LEN_SHORT  = 5'd30;
  localparam day_t LEN_FEB    = 5'd28;
  localparam day_t LEN_FEB_LP = 5'd29;

  localparam logic [9:0] QUAD_CENT = 10'd400;
  localparam ymod_t YMOD_LAST = 9'd399;
  localparam ymod_t CENT_1 = 9'd100;
  localparam ymod_t CENT_2 = 9'd200;
  localparam ymod_t CENT_3 = 9'd300;

  // full gregorian rule, taken from the year modulo 400
  function automatic logic is_leap(input ymod_t r);
    return (r[1:0] == 2'b00) && (r != CENT_1) && (r != CENT_2) && (r != CENT_3);
  endfunction

  // month length table; codes outside 1..12 fall to 31 and are screened elsewhere
  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    case (m)
      MON_FEB: len = leap ? LEN_FEB_LP : LEN_FEB;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
      default: len = DAY_LAST;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cda_mod_unit.sv -----
// reciprocal year-modulo-400 unit: capture, multiply, fold, each a registered step
`default_nettype none

module cda_mod_unit #(
  parameter int YEAR_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [YEAR_BITS-1:0] year,
  output logic                      done,
  output cda_pkg::ymod_t            ymod
);

  // year mod 400 = 16 * ((year / 16) mod 25) + year mod 16
  localparam int ZB = YEAR_BITS - 4;
  localparam int SH = ZB + 5;
  localparam int PW = 2 * ZB + 6;
  // ceil(2^SH / 25) gives the exact quotient by 25 for every ZB-bit value
  localparam longint unsigned RECIP_FULL = ((64'd1 << SH) + 64'd24) / 64'd25;
  localparam logic [ZB:0] RECIP = (ZB+1)'(RECIP_FULL);

  logic [ZB-1:0]  sixt_r, sixt_nxt;   // year / 16
  logic [3:0]     low_r, low_nxt;     // year mod 16
  logic [PW-1:0]  prod_r, prod_nxt;
  cda_pkg::ymod_t ymod_r, ymod_nxt;
  logic           mul_r;              // product being formed
  logic           fold_r;             // remainder being formed
  logic           done_r;
  logic [4:0]     quo_lo;
  logic [4:0]     rem25;

  // only the low bits of the quotient matter, the remainder is below 25
  assign quo_lo = prod_r[SH +: 5];
  assign rem25  = 5'(sixt_r) - quo_lo * 5'd25;

  always_comb begin
    sixt_nxt = sixt_r;
    low_nxt  = low_r;
    prod_nxt = prod_r;
    ymod_nxt = ymod_r;
    if (start) begin
      sixt_nxt = year[YEAR_BITS-1:4];
      low_nxt  = year[3:0];
    end
    if (mul_r) begin
      prod_nxt = PW'(sixt_r) * PW'(RECIP);
    end
    if (fold_r) begin
      ymod_nxt = {rem25, low_r};
    end
  end

  always_ff @(posedge clk) begin
    sixt_r <= sixt_nxt;
    low_r  <= low_nxt;
    prod_r <= prod_nxt;
    ymod_r <= ymod_nxt;
    if (!rst_n) begin
      mul_r  <= 1'b0;
      fold_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= start;
      fold_r <= mul_r;
      done_r <= fold_r;
    end
  end

  assign done = done_r;
  assign ymod = ymod_r;

endmodule

`default_nettype wire

// ----- hw/rtl/cda_step.sv -----
// one month of the day walk: fits in this month, or move to the next one, or saturate at the top year
`default_nettype none

module cda_step #(
  parameter int YEAR_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic [YEAR_BITS-1:0]  year,
  input  wire cda_pkg::month_t       month,
  input  wire cda_pkg::day_t         day,
  input  wire cda_pkg::ymod_t        ymod,
  input  wire logic [COUNT_BITS-1:0] rem,
  output logic [YEAR_BITS-1:0]       year_n,
  output cda_pkg::month_t            month_n,
  output cda_pkg::day_t              day_n,
  output cda_pkg::ymod_t             ymod_n,
  output logic [COUNT_BITS-1:0]      rem_n,
  output cda_pkg::step_stat_t        stat
);

  cda_pkg::day_t        len;
  logic [COUNT_BITS:0]  sum;
  logic [5:0]           used;

  assign len  = cda_pkg::month_len(month, cda_pkg::is_leap(ymod));
  assign sum  = (COUNT_BITS+1)'(day) + {1'b0, rem};
  // days consumed to reach the first of next month
  assign used = {1'b0, len} - {1'b0, day} + 6'd1;

  always_comb begin
    year_n  = year;
    month_n = month;
    day_n   = day;
    ymod_n  = ymod;
    rem_n   = rem;
    stat    = '0;
    if (sum <= (COUNT_BITS+1)'(len)) begin
      day_n       = sum[4:0];
      stat.finish = 1'b1;
    end else begin
      rem_n = rem - COUNT_BITS'(used);
      day_n = cda_pkg::DAY_FIRST;
      if (month >= cda_pkg::MON_DEC) begin
        if (&year) begin
          // saturate at the last day of the largest year
          month_n       = cda_pkg::MON_DEC;
          day_n         = cda_pkg::DAY_LAST;
          stat.finish   = 1'b1;
          stat.overflow = 1'b1;
        end else begin
          year_n  = year + YEAR_BITS'(1);
          month_n = cda_pkg::MON_JAN;
          ymod_n  = (ymod == cda_pkg::YMOD_LAST) ? '0 : ymod + 9'd1;
        end
      end else begin
        month_n = month + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/calendar_date_add_days.sv -----
// top level of the calendar date register with day addition
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: kind; tdata: year, month, day, count
//  out_    | out | out_tvalid/out_tready| tdata: year, month, day; tuser: two flags
//
//  load item: capture, multiply and fold in the modulo-400 unit, then a check, then issue
//  add item: the shared step unit walks one month per cycle until the count is used up
//    or the top year saturates, then issue
//  rst_n (synchronous) gives 1 January of year 0; no clearing pass
//  in_tready is high only in idle; a result waiting in the output register does not
//    hold off the next item, only its issue
`default_nettype none

module calendar_date_add_days #(
  parameter int YEAR_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // new_year[15:0], new_month[19:16], new_day[24:20],
                                       // day_count[40:25], zero[47:41]
  input  wire logic [0:0]  in_tuser,   // kind[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_year[15:0], out_month[19:16], out_day[24:20],
                                       // zero[31:25]
  output logic [1:0]       out_tuser   // set_rejected[0], year_overflow[1]
);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]            state_r, state_nxt;

  // the held date and its year modulo 400
  logic [YEAR_BITS-1:0]  cur_year_r, cur_year_nxt;
  cda_pkg::month_t       cur_month_r, cur_month_nxt;
  cda_pkg::day_t         cur_day_r, cur_day_nxt;
  cda_pkg::ymod_t        cur_ymod_r, cur_ymod_nxt;

  // working registers of the item in progress
  logic [YEAR_BITS-1:0]  ld_year_r, ld_year_nxt;
  cda_pkg::month_t       ld_month_r, ld_month_nxt;
  cda_pkg::day_t         ld_day_r, ld_day_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic                  rej_r, rej_nxt;
  logic                  ovf_r, ovf_nxt;

  // output register
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [31:0]           out_tdata_r, out_tdata_nxt;
  logic [1:0]            out_tuser_r, out_tuser_nxt;

  logic                  in_acc;
  logic                  mod_start;
  logic                  mod_done;
  cda_pkg::ymod_t        mod_val;
  logic                  ld_ok;

  logic [YEAR_BITS-1:0]  st_year;
  cda_pkg::month_t       st_month;
  cda_pkg::day_t         st_day;
  cda_pkg::ymod_t        st_ymod;
  logic [COUNT_BITS-1:0] st_rem;
  cda_pkg::step_stat_t   st_stat;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign mod_start = in_acc && (in_tuser[0] == cda_pkg::KIND_LOAD);

  // year modulo 400 of a date being loaded, for the leap check
  cda_mod_unit #(
    .YEAR_BITS(YEAR_BITS)
  ) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mod_start),
    .year (ld_year_nxt),
    .done (mod_done),
    .ymod (mod_val)
  );

  // shared month step, reused every walk cycle
  cda_step #(
    .YEAR_BITS (YEAR_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .year   (cur_year_r),
    .month  (cur_month_r),
    .day    (cur_day_r),
    .ymod   (cur_ymod_r),
    .rem    (rem_r),
    .year_n (st_year),
    .month_n(st_month),
    .day_n  (st_day),
    .ymod_n (st_ymod),
    .rem_n  (st_rem),
    .stat   (st_stat)
  );

  // a load must be a real date in the leap sense of its own year
  assign ld_ok = (ld_month_r >= cda_pkg::MON_JAN) && (ld_month_r <= cda_pkg::MON_DEC) &&
                 (ld_day_r >= cda_pkg::DAY_FIRST) &&
                 (ld_day_r <= cda_pkg::month_len(ld_month_r, cda_pkg::is_leap(mod_val)));

  always_comb begin
    state_nxt      = state_r;
    cur_year_nxt   = cur_year_r;
    cur_month_nxt  = cur_month_r;
    cur_day_nxt    = cur_day_r;
    cur_ymod_nxt   = cur_ymod_r;
    ld_year_nxt    = ld_year_r;
    ld_month_nxt   = ld_month_r;
    ld_day_nxt     = ld_day_r;
    rem_nxt        = rem_r;
    rej_nxt        = rej_r;
    ovf_nxt        = ovf_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ld_year_nxt  = YEAR_BITS'(in_tdata[15:0]);
          ld_month_nxt = in_tdata[19:16];
          ld_day_nxt   = in_tdata[24:20];
          rem_nxt      = COUNT_BITS'(in_tdata[40:25]);
          rej_nxt      = 1'b0;
          ovf_nxt      = 1'b0;
          state_nxt    = (in_tuser[0] == cda_pkg::KIND_LOAD) ? S_MOD : S_WALK;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (ld_ok) begin
          cur_year_nxt  = ld_year_r;
          cur_month_nxt = ld_month_r;
          cur_day_nxt   = ld_day_r;
          cur_ymod_nxt  = mod_val;
        end
        rej_nxt   = !ld_ok;
        state_nxt = S_DONE;
      end
      S_WALK: begin
        cur_year_nxt  = st_year;
        cur_month_nxt = st_month;
        cur_day_nxt   = st_day;
        cur_ymod_nxt  = st_ymod;
        rem_nxt       = st_rem;
        ovf_nxt       = st_stat.overflow;
        if (st_stat.finish) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // issue once the output register is free or being emptied
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {7'd0, cur_day_r, cur_month_r, 16'(cur_year_r)};
          out_tuser_nxt  = {ovf_r, rej_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ld_year_r   <= ld_year_nxt;
    ld_month_r  <= ld_month_nxt;
    ld_day_r    <= ld_day_nxt;
    rem_r       <= rem_nxt;
    rej_r       <= rej_nxt;
    ovf_r       <= ovf_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_year_r   <= '0;
      cur_month_r  <= cda_pkg::MON_JAN;
      cur_day_r    <= cda_pkg::DAY_FIRST;
      cur_ymod_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_year_r   <= cur_year_nxt;
      cur_month_r  <= cur_month_nxt;
      cur_day_r    <= cur_day_nxt;
      cur_ymod_r   <= cur_ymod_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef NO_ASSERTIONS
  // the held date always stays a real month
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_month_r >= cda_pkg::MON_JAN) && (cur_month_r <= cda_pkg::MON_DEC))
    else $error("held month out of range");

  // the tracked year modulo 400 never reaches 400
  a_ymod_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_ymod_r <= cda_pkg::YMOD_LAST)
    else $error("year modulo 400 out of range");

  // a load and an add flag never appear together
  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tuser_r[0] && out_tuser_r[1]))
    else $error("both result flags set");

  // an overflowed add ends on 31 december
  a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r[1]) |->
      (out_tdata_r[19:16] == cda_pkg::MON_DEC) && (out_tdata_r[24:20] == cda_pkg::DAY_LAST))
    else $error("overflow result not saturated");

  // an accepted item leaves idle at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after accept");
`endif

endmodule

`default_nettype wire

// ----- test/calendar_date_add_days_tb.sv -----
// self-checking testbench for the calendar date register with day addition
module calendar_date_add_days_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 400;        // output back-pressure stretch
  localparam int TIMEOUT_CYCLES = 2_500_000;
  localparam logic [15:0] YEAR_TOP = 16'hFFFF;
  localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // golden date register plus the queue of dates still owed by the block
  class date_scoreboard;
    typedef struct {
      logic [15:0]     year;
      cda_pkg::month_t month;
      cda_pkg::day_t   day;
      logic            rejected;
      logic            overflow;
    } date_result_t;

    date_result_t    expected_dates[$];
    logic [15:0]     cur_year;
    cda_pkg::month_t cur_month;
    cda_pkg::day_t   cur_day;
    int mismatches, n_checked, n_loads, n_adds, n_rejected, n_overflows;

    function new();
      cur_year  = '0;
      cur_month = cda_pkg::MON_JAN;
      cur_day   = cda_pkg::DAY_FIRST;
    endfunction

    function logic leap_year(logic [15:0] y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // only for months 1..12
    function cda_pkg::day_t month_days(logic [15:0] y, cda_pkg::month_t m);
      if (m == cda_pkg::MON_FEB) return leap_year(y) ? cda_pkg::LEN_FEB_LP : cda_pkg::LEN_FEB;
      return cda_pkg::day_t'(MONTH_LEN[int'(m) - 1]);
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction

    // advance the golden date for one accepted item and queue the date it yields
    function void note_item(logic kind, logic [15:0] y, cda_pkg::month_t m, cda_pkg::day_t d,
                            logic [15:0] cnt);
      date_result_t r;
      int unsigned  left;
      int unsigned  len;
      logic         walking;
      r.rejected = 1'b0;
      r.overflow = 1'b0;
      if (kind == cda_pkg::KIND_LOAD) begin
        n_loads++;
        if (m < cda_pkg::MON_JAN || m > cda_pkg::MON_DEC || d < cda_pkg::DAY_FIRST ||
            d > month_days(y, m)) begin
          r.rejected = 1'b1;
          n_rejected++;
        end else begin
          cur_year  = y;
          cur_month = m;
          cur_day   = d;
        end
      end else begin
        n_adds++;
        left    = cnt;
        walking = 1'b1;
        while (walking) begin
          len = month_days(cur_year, cur_month);
          if (int'(cur_day) + left <= len) begin
            cur_day = cda_pkg::day_t'(int'(cur_day) + left);
            walking = 1'b0;
          end else begin
            left    = left - (len - cur_day + 1);
            cur_day = cda_pkg::DAY_FIRST;
            if (cur_month == cda_pkg::MON_DEC) begin
              if (cur_year == YEAR_TOP) begin
                cur_day    = cda_pkg::DAY_LAST;
                r.overflow = 1'b1;
                n_overflows++;
                walking    = 1'b0;
              end else begin
                cur_year  = cur_year + 1'b1;
                cur_month = cda_pkg::MON_JAN;
              end
            end else begin
              cur_month = cur_month + 1'b1;
            end
          end
        end
      end
      r.year  = cur_year;
      r.month = cur_month;
      r.day   = cur_day;
      expected_dates.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic [31:0] tdata, logic [1:0] tuser);
      date_result_t want;
      if (expected_dates.size() == 0) begin
        report_mismatch($sformatf("result %h/%h with no item outstanding", tdata, tuser));
        return;
      end
      want = expected_dates.pop_front();
      n_checked++;
      if (tdata[15:0] !== want.year)
        report_mismatch($sformatf("result %0d year %0d, want %0d",
                                  n_checked, tdata[15:0], want.year));
      if (tdata[19:16] !== want.month)
        report_mismatch($sformatf("result %0d month %0d, want %0d",
                                  n_checked, tdata[19:16], want.month));
      if (tdata[24:20] !== want.day)
        report_mismatch($sformatf("result %0d day %0d, want %0d",
                                  n_checked, tdata[24:20], want.day));
      if (tuser[0] !== want.rejected)
        report_mismatch($sformatf("result %0d set_rejected %b, want %b",
                                  n_checked, tuser[0], want.rejected));
      if (tuser[1] !== want.overflow)
        report_mismatch($sformatf("result %0d year_overflow %b, want %b",
                                  n_checked, tuser[1], want.overflow));
    endtask
  endclass

  // clock, reset and the block's inputs, all known from time zero
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [47:0] in_tdata   = '0;   // new_year[15:0], new_month[19:16], new_day[24:20],
                                  // day_count[40:25], zero[47:41]
  logic [0:0]  in_tuser   = '0;   // kind[0]
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;         // out_year[15:0], out_month[19:16], out_day[24:20],
                                  // zero[31:25]
  logic [1:0]  out_tuser;         // set_rejected[0], year_overflow[1]

  date_scoreboard sb = new();

  // pacing knobs, percentages of cycles spent idle on each side
  int tx_idle_pct = 34;
  int rx_idle_pct = 85;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_gen    = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  calendar_date_add_days #(
    .YEAR_BITS (16),
    .COUNT_BITS(16)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // bus monitor: results are checked before the same edge's input is noted, although a
  // result can never belong to an item accepted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready)
        sb.note_item(in_tuser[0], in_tdata[15:0], in_tdata[19:16], in_tdata[24:20],
                     in_tdata[40:25]);
    end
  end

  // receiver: random ready, or a long hold-off when the stimulus asks for one
  initial begin : receiver
    int seen_gen;
    seen_gen = 0;
    forever begin
      @(posedge clk);
      if (hold_gen != seen_gen) begin
        seen_gen = hold_gen;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one item, with random idle cycles first; valid stays high on return so that
  // back-to-back items never drop it
  task automatic send_item(input logic kind, input logic [15:0] y, input cda_pkg::month_t m,
                           input cda_pkg::day_t d, input logic [15:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, cnt, d, m, y};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // load items carry a random count, add items random date fields, both ignored
  task automatic load_date(input logic [15:0] y, input cda_pkg::month_t m,
                           input cda_pkg::day_t d);
    send_item(cda_pkg::KIND_LOAD, y, m, d, 16'($urandom));
  endtask

  task automatic add_days(input logic [15:0] cnt);
    send_item(cda_pkg::KIND_ADD, 16'($urandom), 4'($urandom), 5'($urandom), cnt);
  endtask

  // sender stops until every owed date is back, then lets the block go quiet
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly real dates and short walks; some junk loads, a few very long walks
  task automatic random_item();
    int              sel;
    logic [15:0]     y;
    logic [15:0]     cnt;
    cda_pkg::month_t m;
    cda_pkg::day_t   d;
    y   = 16'($urandom);
    m   = 4'($urandom_range(15));
    d   = 5'($urandom);
    cnt = 16'($urandom);
    if ($urandom_range(99) < 45) begin
      sel = $urandom_range(99);
      if (sel < 25) y = 16'($urandom_range(2404, 1596));       // century leap rules
      else if (sel < 40) y = 16'($urandom_range(65535, 65500)); // near saturation
      if ($urandom_range(99) < 85) begin
        m = 4'($urandom_range(12, 1));
        d = 5'($urandom_range(sb.month_days(y, m), 1));
      end
      send_item(cda_pkg::KIND_LOAD, y, m, d, 16'($urandom));
    end else begin
      sel = $urandom_range(99);
      if (sel < 70) cnt = 16'($urandom_range(60));
      else if (sel < 90) cnt = 16'($urandom_range(2000));
      else if (sel < 98) cnt = 16'($urandom_range(20000));
      send_item(cda_pkg::KIND_ADD, y, m, d, cnt);
    end
  endtask

  initial begin : stimulus
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: start from the reset date, year 0 is a leap year
    add_days(16'd0);
    add_days(16'd59);
    // leap rule: divisible by 400, by 100 only, not at all, by 4
    load_date(16'd2000, cda_pkg::MON_FEB, cda_pkg::LEN_FEB_LP);
    load_date(16'd1900, cda_pkg::MON_FEB, cda_pkg::LEN_FEB_LP);
    load_date(16'd2023, cda_pkg::MON_FEB, cda_pkg::LEN_FEB_LP);
    load_date(16'd2024, cda_pkg::MON_FEB, cda_pkg::LEN_FEB_LP);
    // refused loads: month zero, all month bits set, month 13, day zero, 31 April
    load_date(YEAR_TOP, 4'd0, cda_pkg::DAY_FIRST);
    load_date(16'd1234, 4'hF, cda_pkg::DAY_LAST);
    load_date(16'd1234, 4'd13, cda_pkg::DAY_FIRST);
    load_date(16'd1234, cda_pkg::MON_JAN, 5'd0);
    load_date(16'd2010, cda_pkg::MON_APR, cda_pkg::DAY_LAST);
    // saturation at the last day of the largest year
    load_date(YEAR_TOP, cda_pkg::MON_DEC, cda_pkg::DAY_LAST);
    add_days(16'd1);
    add_days(16'd0);
    load_date(YEAR_TOP, cda_pkg::MON_DEC, cda_pkg::DAY_FIRST);
    add_days(16'd30);
    add_days(16'hFFFF);
    load_date(16'd65400, cda_pkg::MON_JAN, cda_pkg::DAY_FIRST);
    add_days(16'hFFFF);
    // full-count walk from the bottom of the year range
    load_date(16'd0, cda_pkg::MON_JAN, cda_pkg::DAY_FIRST);
    add_days(16'hFFFF);
    // year, century and leap-day boundaries
    load_date(16'd1999, cda_pkg::MON_DEC, cda_pkg::DAY_LAST);
    add_days(16'd1);
    load_date(16'd2100, cda_pkg::MON_FEB, cda_pkg::LEN_FEB);
    add_days(16'd1);
    wait_results();

    // long output stall while the sender keeps pushing, so in_tready must drop
    tx_idle_pct = 0;
    hold_gen    = hold_gen + 1;
    for (i = 0; i < 4; i++) begin
      load_date(16'($urandom_range(2404, 1596)), cda_pkg::MON_SEP, cda_pkg::LEN_SHORT);
      add_days(16'($urandom_range(40)));
    end
    wait_results();

    // slow receiver, then slow sender, then both flat out
    tx_idle_pct = 34;
    rx_idle_pct = 85;
    repeat (80) random_item();
    tx_idle_pct = 85;
    rx_idle_pct = 34;
    repeat (80) random_item();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (80) random_item();
    wait_results();

    $display("covered %0d loads (%0d refused) and %0d additions (%0d saturated at the top year)",
             sb.n_loads, sb.n_rejected, sb.n_adds, sb.n_overflows);
    $display("%0d dates compared across three pacing mixes and one long output stall",
             sb.n_checked);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard, sized from the slowest legal walk on every item
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d dates still owed", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/cda_pkg.sv
hw/rtl/cda_mod_unit.sv
hw/rtl/cda_step.sv
hw/rtl/calendar_date_add_days.sv
test/calendar_date_add_days_tb.sv
